// ----- sv/rgb2hsl_pkg.sv -----
package rgb2hsl_pkg;

  localparam int FRAC_BITS = 6;
  localparam int SCALE     = 1 << FRAC_BITS;

  localparam int CH_W   = 8;
  localparam int OP_W   = 2;
  localparam int OUT_W  = 15;
  localparam int SUM_W  = CH_W + 1;
  localparam int BASE_W = 17;              // hue numerator in degrees * spread
  localparam int DEN_W  = 9;               // up to 510
  localparam int D_W    = DEN_W + 1;       // doubled divisor
  localparam int QW     = $clog2(360 * SCALE);
  localparam int N_W    = QW + D_W;        // dividend width, quotient always fits QW
  localparam int PREP_STAGES = 3;

  localparam int IN_TDATA_W  = 3 * CH_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_HUE   = 2'd0,
    OP_SAT   = 2'd1,
    OP_LIGHT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // one slot of the divider chain
  typedef struct packed {
    logic            valid;
    logic [D_W-1:0]  rem;
    logic [QW-1:0]   nq;    // dividend bits shift out on top, quotient bits in below
    logic [D_W-1:0]  d;
  } div_word_t;

endpackage

// ----- sv/rgb2hsl_prep.sv -----
module rgb2hsl_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [rgb2hsl_pkg::CH_W-1:0]  red,
  input  logic [rgb2hsl_pkg::CH_W-1:0]  green,
  input  logic [rgb2hsl_pkg::CH_W-1:0]  blue,
  input  rgb2hsl_pkg::op_t              opcode,
  output rgb2hsl_pkg::div_word_t        word_out
);
  import rgb2hsl_pkg::*;

  localparam int HUE_W  = BASE_W + 2;
  localparam int NUM0_W = BASE_W + 7;

  typedef enum logic [1:0] {
    SX_RED      = 2'd0,
    SX_GREEN    = 2'd1,
    SX_BLUE     = 2'd2,
    SX_RED_WRAP = 2'd3
  } sext_t;

  // stage 1: max, min, sextant
  logic                    v1_r;
  op_t                     op1_r;
  logic [CH_W-1:0]         spread1_r, spread1_nxt;
  logic [SUM_W-1:0]        sum1_r, sum1_nxt;
  logic signed [CH_W:0]    diff1_r, diff1_nxt;
  sext_t                   sx1_r, sx1_nxt;

  logic            r_max, g_max;
  logic [CH_W-1:0] mx, mn;

  always_comb begin
    r_max = (red >= green) && (red >= blue);
    g_max = !r_max && (green >= blue);
    if (r_max) begin
      mx = red;
    end else if (g_max) begin
      mx = green;
    end else begin
      mx = blue;
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    sum1_nxt    = SUM_W'(mx) + SUM_W'(mn);
    spread1_nxt = mx - mn;
    if (r_max) begin
      diff1_nxt = $signed({1'b0, green}) - $signed({1'b0, blue});
      sx1_nxt   = (green < blue) ? SX_RED_WRAP : SX_RED;
    end else if (g_max) begin
      diff1_nxt = $signed({1'b0, blue}) - $signed({1'b0, red});
      sx1_nxt   = SX_GREEN;
    end else begin
      diff1_nxt = $signed({1'b0, red}) - $signed({1'b0, green});
      sx1_nxt   = SX_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r     <= opcode;
      spread1_r <= spread1_nxt;
      sum1_r    <= sum1_nxt;
      diff1_r   <= diff1_nxt;
      sx1_r     <= sx1_nxt;
    end
  end

  // stage 2: pick numerator base and denominator per opcode
  logic               v2_r;
  logic [BASE_W-1:0]  base2_r, base2_nxt;
  logic [DEN_W-1:0]   den2_r, den2_nxt;
  logic               mul2_r, mul2_nxt;

  logic [8:0]               off_deg;
  logic [BASE_W-1:0]        offp;
  logic signed [HUE_W-1:0]  hsum;

  always_comb begin
    case (sx1_r)
      SX_RED:      off_deg = 9'd0;
      SX_GREEN:    off_deg = 9'd120;
      SX_BLUE:     off_deg = 9'd240;
      SX_RED_WRAP: off_deg = 9'd360;
      default:     off_deg = 9'd0;
    endcase
    offp = BASE_W'(off_deg) * BASE_W'(spread1_r);
    hsum = HUE_W'(diff1_r) * HUE_W'(60) + $signed({2'b00, offp});

    base2_nxt = '0;
    den2_nxt  = DEN_W'(1);
    mul2_nxt  = 1'b0;
    case (op1_r)
      OP_LIGHT: begin
        base2_nxt = BASE_W'(sum1_r);
        den2_nxt  = DEN_W'(510);
        mul2_nxt  = 1'b1;
      end
      OP_SAT: begin
        if (spread1_r != '0) begin
          base2_nxt = BASE_W'(spread1_r);
          den2_nxt  = (sum1_r > SUM_W'(255)) ? DEN_W'(10'd510 - 10'(sum1_r)) : sum1_r;
          mul2_nxt  = 1'b1;
        end
      end
      OP_HUE: begin
        if (spread1_r != '0) begin
          base2_nxt = hsum[HUE_W-1] ? '0 : hsum[BASE_W-1:0];
          den2_nxt  = DEN_W'(spread1_r);
        end
      end
      default: begin
        base2_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base2_r <= base2_nxt;
      den2_r  <= den2_nxt;
      mul2_r  <= mul2_nxt;
    end
  end

  // stage 3: dividend 2*num*scale + den over divisor 2*den gives round half up
  div_word_t         w3_r, w3_nxt;
  logic [NUM0_W-1:0] numv;
  logic [N_W-1:0]    n_full;

  always_comb begin
    numv   = mul2_r ? NUM0_W'(base2_r * 7'd100) : NUM0_W'(base2_r);
    n_full = (N_W'(numv) << (FRAC_BITS + 1)) + N_W'(den2_r);
    w3_nxt.valid = v2_r;
    w3_nxt.rem   = n_full[N_W-1:QW];
    w3_nxt.nq    = n_full[QW-1:0];
    w3_nxt.d     = {den2_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w3_r.valid <= 1'b0;
    end else if (en) begin
      w3_r.valid <= w3_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w3_r.rem <= w3_nxt.rem;
      w3_r.nq  <= w3_nxt.nq;
      w3_r.d   <= w3_nxt.d;
    end
  end

  assign word_out = w3_r;

endmodule

// ----- sv/rgb2hsl_div_cell.sv -----
module rgb2hsl_div_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  rgb2hsl_pkg::div_word_t  word_in,
  output rgb2hsl_pkg::div_word_t  word_out
);
  import rgb2hsl_pkg::*;

  div_word_t      w_r, w_nxt;
  logic [D_W:0]   t, dif;
  logic           ge;

  // one restoring step: bring down a dividend bit, subtract if it fits
  always_comb begin
    t   = {word_in.rem, word_in.nq[QW-1]};
    dif = t - {1'b0, word_in.d};
    ge  = (t >= {1'b0, word_in.d});
    w_nxt.valid = word_in.valid;
    w_nxt.rem   = ge ? dif[D_W-1:0] : t[D_W-1:0];
    w_nxt.nq    = {word_in.nq[QW-2:0], ge};
    w_nxt.d     = word_in.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.valid <= 1'b0;
    end else if (en) begin
      w_r.valid <= w_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r.rem <= w_nxt.rem;
      w_r.nq  <= w_nxt.nq;
      w_r.d   <= w_nxt.d;
    end
  end

  assign word_out = w_r;

endmodule

// ----- sv/rgb_to_hsl_converter_unit.sv -----
// Pipeline from input accept to out_tvalid: three setup stages, then
//   one divider cell per quotient bit.
// Throughput: one pixel per cycle; the whole chain advances together and holds
//   while a result waits on out_tready.
// Reset: synchronous active-low rst_n clears every stage valid bit; data registers are not reset.
module rgb_to_hsl_converter_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [rgb2hsl_pkg::IN_TDATA_W-1:0]    in_tdata,   // red, green, blue
  input  logic [rgb2hsl_pkg::OP_W-1:0]          in_tuser,   // opcode
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rgb2hsl_pkg::OUT_TDATA_W-1:0]   out_tdata   // component_value, zero pad
);
  import rgb2hsl_pkg::*;

  logic      en;
  div_word_t chain [QW+1];

  // advance unless a finished word is stalled at the end
  assign en        = !chain[QW].valid || out_tready;
  assign in_tready = en;

  rgb2hsl_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .red      (in_tdata[CH_W-1:0]),
    .green    (in_tdata[2*CH_W-1:CH_W]),
    .blue     (in_tdata[3*CH_W-1:2*CH_W]),
    .opcode   (op_t'(in_tuser)),
    .word_out (chain[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    rgb2hsl_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .word_in  (chain[i]),
      .word_out (chain[i+1])
    );
  end

  assign out_tvalid = chain[QW].valid;
  assign out_tdata  = OUT_TDATA_W'(OUT_W'(chain[QW].nq));

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

class hsl_scoreboard;
  logic [rgb2hsl_pkg::OUT_W-1:0] expected_components[$];
  int mismatches = 0;

  function automatic longint unsigned div_round_half_up(longint unsigned num,
                                                        longint unsigned den);
    if (den == 0) return 0;
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [rgb2hsl_pkg::OUT_W-1:0] hsl_component_of(
      logic [7:0] r, logic [7:0] g, logic [7:0] b, rgb2hsl_pkg::op_t op);
    longint unsigned scale;
    longint unsigned mx;
    longint unsigned mn;
    longint unsigned sum;
    longint unsigned spread;
    longint unsigned den;
    longint unsigned val;
    longint hue_num;
    scale = longint'(1) << rgb2hsl_pkg::FRAC_BITS;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = mx + mn;
    spread = mx - mn;
    val = 0;
    case (op)
      rgb2hsl_pkg::OP_LIGHT: val = div_round_half_up(sum * 100 * scale, 510);
      rgb2hsl_pkg::OP_SAT: begin
        if (spread != 0) begin
          den = (sum > 255) ? (510 - sum) : sum;
          val = div_round_half_up(spread * 100 * scale, den);
        end
      end
      rgb2hsl_pkg::OP_HUE: begin
        if (spread != 0) begin
          // red wins ties for the maximum, then green
          if (mx == r) begin
            hue_num = 60 * (longint'(g) - longint'(b));
            if (g < b) hue_num += 360 * longint'(spread);
          end else if (mx == g) begin
            hue_num = 60 * (longint'(b) - longint'(r)) + 120 * longint'(spread);
          end else begin
            hue_num = 60 * (longint'(r) - longint'(g)) + 240 * longint'(spread);
          end
          if (hue_num < 0) hue_num = 0;
          val = div_round_half_up(longint'(hue_num) * scale, spread);
        end
      end
      default: val = 0;
    endcase
    return val[rgb2hsl_pkg::OUT_W-1:0];
  endfunction

  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           rgb2hsl_pkg::op_t op);
    expected_components.push_back(hsl_component_of(r, g, b, op));
  endfunction

  function void check_word(logic [rgb2hsl_pkg::OUT_TDATA_W-1:0] word);
    logic [rgb2hsl_pkg::OUT_TDATA_W-1:0] want;
    if (expected_components.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word 0x%0h", word);
      return;
    end
    // pad bits above the component must be zero
    want = rgb2hsl_pkg::OUT_TDATA_W'(expected_components.pop_front());
    if (word !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("component mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                 want, want, word, word);
    end
  endfunction
endclass

module tb;
  import rgb2hsl_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = PREP_STAGES + QW + 8;
  localparam int RANDOM_ITEMS = 2000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  hsl_scoreboard sb = new();
  int in_gap_pct = 0;
  int out_gap_pct = 0;
  int stall_left = 0;
  int cycles = 0;

  rgb_to_hsl_converter_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rgb_to_hsl_converter_unit");
      $finish;
    end
  end

  // result side: check accepted words, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input op_t op);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(r, g, b, op);
  endtask

  task automatic send_all_ops(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
    send_pixel(r, g, b, OP_HUE);
    send_pixel(r, g, b, OP_SAT);
    send_pixel(r, g, b, OP_LIGHT);
    send_pixel(r, g, b, OP_NONE);
  endtask

  initial begin
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    in_gap_pct  = 20;
    out_gap_pct = 20;
    // black and white, grey: hue and saturation are zero
    send_all_ops(8'd0, 8'd0, 8'd0);
    send_all_ops(8'd255, 8'd255, 8'd255);
    // pure primaries
    send_all_ops(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0, OP_HUE);
    send_pixel(8'd0, 8'd0, 8'd255, OP_HUE);
    // ties for the maximum
    send_pixel(8'd255, 8'd255, 8'd0, OP_HUE);
    send_pixel(8'd0, 8'd255, 8'd255, OP_HUE);
    send_pixel(8'd255, 8'd0, 8'd255, OP_HUE);
    // red max with blue above green wraps the hue
    send_pixel(8'd200, 8'd10, 8'd50, OP_HUE);
    // saturation on both sides of the midpoint, smallest divisors
    send_pixel(8'd100, 8'd20, 8'd50, OP_SAT);
    send_pixel(8'd255, 8'd128, 8'd200, OP_SAT);
    send_pixel(8'd1, 8'd0, 8'd0, OP_SAT);
    send_pixel(8'd255, 8'd254, 8'd254, OP_SAT);
    send_pixel(8'd12, 8'd200, 8'd99, OP_NONE);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 250 == 0) begin
        case ($urandom_range(0, 3))
          0: in_gap_pct = 0;
          1: in_gap_pct = 10;
          2: in_gap_pct = 30;
          default: in_gap_pct = 60;
        endcase
        case ($urandom_range(0, 3))
          0: out_gap_pct = 0;
          1: out_gap_pct = 10;
          2: out_gap_pct = 30;
          default: out_gap_pct = 60;
        endcase
      end
      if (i >= RANDOM_ITEMS - 300) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end
      if (i == RANDOM_ITEMS / 2) begin
        // hold input until the pipe has emptied
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_components.size() != 0) @(posedge clk);
      end
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          g = r;
          b = r;
        end
        1: begin
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = g;
            default: b = r;
          endcase
        end
        2: begin
          g = r ^ 8'($urandom_range(0, 3));
          b = r ^ 8'($urandom_range(0, 3));
        end
        default: ;
      endcase
      send_pixel(r, g, b, op_t'($urandom_range(0, 3)));
    end
    in_tvalid <= 1'b0;

    while (sb.expected_components.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_components.size() == 0) begin
      $display("PASS rgb_to_hsl_converter_unit");
    end else begin
      $display("FAIL rgb_to_hsl_converter_unit");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/rgb2hsl_pkg.sv
sv/rgb2hsl_prep.sv
sv/rgb2hsl_div_cell.sv
sv/rgb_to_hsl_converter_unit.sv
bench/tb.sv
